FILE: hw/rtl/dasr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasr_pkg
// Shared constants, codes and controller/datapath types of the two-axis
// stepper speed ramp.
// ----------------------------------------------------------------------------
package dasr_pkg;

	localparam int PERIOD_BITS_DEF  = 16;
	localparam int SPEED_BITS       = 21;
	localparam int ACCEL_BITS       = 16;
	localparam int POS_BITS         = 32;
	localparam int OP_BITS          = 2;
	localparam int CFG_IDX_BITS     = 2;
	localparam int SPEED_LIMIT      = 1000000;
	localparam int TICKS_PER_SECOND = 1000000;
	localparam int IDLE_PERIOD      = 255;
	localparam int DIV_BITS         = 20;
	localparam int DIV_STEPS        = DIV_BITS;
	localparam int DIV_CNT_BITS     = $clog2(DIV_STEPS);

	localparam logic [OP_BITS-1:0] OP_TICK = 2'd0;
	localparam logic [OP_BITS-1:0] OP_RAMP = 2'd1;
	localparam logic [OP_BITS-1:0] OP_GOAL = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_PAN_ACCEL  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TILT_ACCEL = 2'd1;

	localparam logic signed [SPEED_BITS:0] SAT_HI = (SPEED_BITS+1)'(SPEED_LIMIT);
	localparam logic signed [SPEED_BITS:0] SAT_LO = -SAT_HI;

	typedef struct packed {
		logic latch_in;
		logic do_tick;
		logic do_goal;
		logic do_ramp;
		logic div_load;
		logic div_run;
		logic reload;
		logic load_out;
	} dasr_cmd_t;

	typedef struct packed {
		logic div_last;
	} dasr_status_t;

	function automatic logic signed [SPEED_BITS-1:0] sat_speed(
		input logic signed [SPEED_BITS:0] v
	);
		logic signed [SPEED_BITS:0] r;
		begin
			r = v;
			if (v > SAT_HI)
				r = SAT_HI;
			else if (v < SAT_LO)
				r = SAT_LO;
			return r[SPEED_BITS-1:0];
		end
	endfunction

endpackage

FILE: hw/rtl/dasr_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasr_axis
// One axis: goal and speed ramp, serial period divider, period counter,
// step direction and position count.
// ----------------------------------------------------------------------------
module dasr_axis import dasr_pkg::*; #(
	parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dasr_cmd_t                    cmd,
	input  logic                         accel_we,
	input  logic [ACCEL_BITS-1:0]        accel_data,
	input  logic signed [SPEED_BITS-1:0] target,
	output logic                         step,
	output logic                         dir,
	output logic [POS_BITS-1:0]          count,
	output logic signed [SPEED_BITS-1:0] speed,
	output logic                         div_last
);

	localparam int EXT_BITS = (PERIOD_BITS > DIV_BITS) ? PERIOD_BITS : DIV_BITS;

	logic [ACCEL_BITS-1:0]        accel_q;
	logic signed [SPEED_BITS-1:0] target_q;
	logic signed [SPEED_BITS-1:0] goal_q;
	logic signed [SPEED_BITS-1:0] speed_q;
	logic signed [SPEED_BITS-1:0] ramp_next;
	logic signed [SPEED_BITS-1:0] mag;
	logic signed [SPEED_BITS:0]   spd_w;
	logic signed [SPEED_BITS:0]   acc_w;
	logic signed [SPEED_BITS:0]   diff;
	logic                         near;
	logic [DIV_BITS-1:0]          den_q;
	logic [DIV_BITS-1:0]          quo_q;
	logic [DIV_BITS-1:0]          rem_q;
	logic [DIV_BITS:0]            rem_sh;
	logic                         ge;
	logic [DIV_CNT_BITS-1:0]      cnt_q;
	logic [EXT_BITS-1:0]          quo_ext;
	logic [EXT_BITS-1:0]          pmax_ext;
	logic [PERIOD_BITS-1:0]       period_next;
	logic [PERIOD_BITS-1:0]       period_q;
	logic [PERIOD_BITS-1:0]       elapsed_q;
	logic                         wrap;
	logic                         step_q;
	logic                         dir_q;
	logic [POS_BITS-1:0]          count_q;

	// speed ramp
	always_comb begin
		spd_w = (SPEED_BITS+1)'(speed_q);
		acc_w = $signed({{(SPEED_BITS+1-ACCEL_BITS){1'b0}}, accel_q});
		diff  = (SPEED_BITS+1)'(goal_q) - spd_w;
		near  = (diff > -acc_w) && (diff < acc_w);
		if (near)
			ramp_next = goal_q;
		else if (diff > 0)
			ramp_next = sat_speed(spd_w + acc_w);
		else
			ramp_next = sat_speed(spd_w - acc_w);
	end

	// restoring divider, one quotient bit per cycle
	always_comb begin
		mag      = speed_q[SPEED_BITS-1] ? -speed_q : speed_q;
		rem_sh   = {rem_q, quo_q[DIV_BITS-1]};
		ge       = rem_sh >= {1'b0, den_q};
		quo_ext  = EXT_BITS'(quo_q);
		pmax_ext = EXT_BITS'({PERIOD_BITS{1'b1}});
		if (speed_q == '0)
			period_next = PERIOD_BITS'(IDLE_PERIOD);
		else if (quo_ext > pmax_ext)
			period_next = '1;
		else
			period_next = quo_ext[PERIOD_BITS-1:0];
		wrap = elapsed_q >= period_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in)
			target_q <= target;
		if (cmd.div_load) begin
			den_q <= mag[DIV_BITS-1:0];
			quo_q <= DIV_BITS'(TICKS_PER_SECOND);
			rem_q <= '0;
		end else if (cmd.div_run) begin
			rem_q <= ge ? DIV_BITS'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_BITS-1:0];
			quo_q <= {quo_q[DIV_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q   <= '0;
			goal_q    <= '0;
			speed_q   <= '0;
			period_q  <= PERIOD_BITS'(IDLE_PERIOD);
			elapsed_q <= '0;
			count_q   <= '0;
			dir_q     <= 1'b1;
			step_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (accel_we)
				accel_q <= accel_data;
			if (cmd.latch_in)
				step_q <= 1'b0;
			if (cmd.do_goal)
				goal_q <= sat_speed((SPEED_BITS+1)'(target_q));
			if (cmd.do_ramp)
				speed_q <= ramp_next;
			if (cmd.div_load)
				cnt_q <= '0;
			else if (cmd.div_run)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.reload) begin
				period_q  <= period_next;
				elapsed_q <= '0;
			end
			if (cmd.do_tick) begin
				if (wrap) begin
					elapsed_q <= '0;
					if (speed_q > 0) begin
						dir_q   <= 1'b0;
						count_q <= count_q + 1'b1;
						step_q  <= 1'b1;
					end else if (speed_q < 0) begin
						dir_q   <= 1'b1;
						count_q <= count_q - 1'b1;
						step_q  <= 1'b1;
					end
				end else begin
					elapsed_q <= elapsed_q + 1'b1;
				end
			end
		end
	end

	assign step     = step_q;
	assign dir      = dir_q;
	assign count    = count_q;
	assign speed    = speed_q;
	assign div_last = cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1);

endmodule

FILE: hw/rtl/dasr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasr_dp
// Datapath: the pan and tilt axes, configuration decode and the response
// register.
// ----------------------------------------------------------------------------
module dasr_dp import dasr_pkg::*; #(
	parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dasr_cmd_t                    cmd,
	output dasr_status_t                 status,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [ACCEL_BITS-1:0]        cfg_data,
	input  logic signed [SPEED_BITS-1:0] pan_target,
	input  logic signed [SPEED_BITS-1:0] tilt_target,
	output logic                         pan_step,
	output logic                         tilt_step,
	output logic                         pan_dir,
	output logic                         tilt_dir,
	output logic signed [POS_BITS-1:0]   pan_position,
	output logic signed [POS_BITS-1:0]   tilt_position,
	output logic signed [SPEED_BITS-1:0] pan_speed_now,
	output logic signed [SPEED_BITS-1:0] tilt_speed_now
);

	logic                         p_step, t_step, p_dir, t_dir, p_last, t_last;
	logic [POS_BITS-1:0]          p_count, t_count;
	logic signed [SPEED_BITS-1:0] p_speed, t_speed;

	dasr_axis #(.PERIOD_BITS(PERIOD_BITS)) u_pan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.accel_we   (cfg_we && cfg_index == CFG_PAN_ACCEL),
		.accel_data (cfg_data),
		.target     (pan_target),
		.step       (p_step),
		.dir        (p_dir),
		.count      (p_count),
		.speed      (p_speed),
		.div_last   (p_last)
	);

	dasr_axis #(.PERIOD_BITS(PERIOD_BITS)) u_tilt (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.accel_we   (cfg_we && cfg_index == CFG_TILT_ACCEL),
		.accel_data (cfg_data),
		.target     (tilt_target),
		.step       (t_step),
		.dir        (t_dir),
		.count      (t_count),
		.speed      (t_speed),
		.div_last   (t_last)
	);

	// both dividers run in lockstep
	assign status.div_last = p_last & t_last;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pan_step       <= p_step;
			tilt_step      <= t_step;
			pan_dir        <= p_dir;
			tilt_dir       <= t_dir;
			pan_position   <= p_count;
			tilt_position  <= t_count;
			pan_speed_now  <= p_speed;
			tilt_speed_now <= t_speed;
		end
	end

endmodule

FILE: hw/rtl/dasr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasr_ctrl
// Controller: takes one request at a time, sequences the datapath and holds
// the response valid flag.
// ----------------------------------------------------------------------------
module dasr_ctrl import dasr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic [OP_BITS-1:0] op,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  dasr_status_t       status,
	output dasr_cmd_t          cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD,
		S_DIV,
		S_RELOAD,
		S_EMIT
	} state_t;

	state_t             state_q;
	logic [OP_BITS-1:0] op_q;
	logic               rsp_valid_q;
	logic               emit_ok;

	assign emit_ok   = !rsp_valid_q || rsp_ready;
	assign cmd_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.latch_in = cmd_valid;
			S_EXEC: begin
				unique case (op_q)
					OP_TICK: cmd.do_tick = 1'b1;
					OP_RAMP: cmd.do_ramp = 1'b1;
					OP_GOAL: cmd.do_goal = 1'b1;
					default: ;
				endcase
			end
			S_LOAD:   cmd.div_load = 1'b1;
			S_DIV:    cmd.div_run  = 1'b1;
			S_RELOAD: cmd.reload   = 1'b1;
			S_EMIT:   cmd.load_out = emit_ok;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_TICK;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q    <= op;
						state_q <= S_EXEC;
					end
				end
				S_EXEC:   state_q <= (op_q == OP_RAMP) ? S_LOAD : S_EMIT;
				S_LOAD:   state_q <= S_DIV;
				S_DIV: begin
					if (status.div_last)
						state_q <= S_RELOAD;
				end
				S_RELOAD: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit_ok) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/dual_axis_stepper_speed_ramp.sv
`timescale 1ns / 1ps
// Tick, set-goal and unused-op requests go through the execute and emit states;
// a ramp request also goes through load, the one-bit-per-cycle period divider
// and reload (both axes divide side by side). Emit waits while a response is
// unaccepted; a new request is taken only in idle. Reset (arst_n low,
// asynchronous): speeds, goals, accelerations, position counts and counters
// clear, periods go to 255, axis directions go high, no response pending.
// ----------------------------------------------------------------------------
// dual_axis_stepper_speed_ramp
// Two-axis stepper pulse generator with a linear speed ramp.
// ----------------------------------------------------------------------------
module dual_axis_stepper_speed_ramp import dasr_pkg::*; #(
	parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  logic [OP_BITS-1:0]           op,
	input  logic signed [SPEED_BITS-1:0] pan_target,
	input  logic signed [SPEED_BITS-1:0] tilt_target,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic                         pan_step,
	output logic                         tilt_step,
	output logic                         pan_dir,
	output logic                         tilt_dir,
	output logic signed [POS_BITS-1:0]   pan_position,
	output logic signed [POS_BITS-1:0]   tilt_position,
	output logic signed [SPEED_BITS-1:0] pan_speed_now,
	output logic signed [SPEED_BITS-1:0] tilt_speed_now,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [ACCEL_BITS-1:0]        cfg_data
);

	dasr_cmd_t    cmd;
	dasr_status_t status;

	dasr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.op        (op),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dasr_dp #(.PERIOD_BITS(PERIOD_BITS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pan_target     (pan_target),
		.tilt_target    (tilt_target),
		.pan_step       (pan_step),
		.tilt_step      (tilt_step),
		.pan_dir        (pan_dir),
		.tilt_dir       (tilt_dir),
		.pan_position   (pan_position),
		.tilt_position  (tilt_position),
		.pan_speed_now  (pan_speed_now),
		.tilt_speed_now (tilt_speed_now)
	);

endmodule

FILE: hw/rtl/dasr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasr_checker
// Port-level checks of the two-axis stepper speed ramp, bound to the top.
// ----------------------------------------------------------------------------
module dasr_checker import dasr_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         pan_step,
	input logic                         tilt_step,
	input logic                         pan_dir,
	input logic                         tilt_dir,
	input logic signed [POS_BITS-1:0]   pan_position,
	input logic signed [POS_BITS-1:0]   tilt_position,
	input logic signed [SPEED_BITS-1:0] pan_speed_now,
	input logic signed [SPEED_BITS-1:0] tilt_speed_now
);

	// one request in flight at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("request taken while previous one still in work");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(pan_position)
			&& $stable(tilt_position))
		else $error("stalled response dropped or changed");

	a_pan_step_dir: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && pan_step |-> pan_speed_now != '0
			&& pan_dir == pan_speed_now[SPEED_BITS-1])
		else $error("pan step inconsistent with speed sign");

	a_tilt_step_dir: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && tilt_step |-> tilt_speed_now != '0
			&& tilt_dir == tilt_speed_now[SPEED_BITS-1])
		else $error("tilt step inconsistent with speed sign");

endmodule

bind dual_axis_stepper_speed_ramp dasr_checker u_dasr_checker (.*);
